[hw/rtl/bls_pkg.sv]
// ----------------------------------------------------------------------------
// bls_pkg
// Types, widths and helpers shared by the Bresenham line stepper modules.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int CoordBits = 9;
  localparam int ColorBits = 16;
  // 2*|dminor| fits CoordBits+1; one more bit keeps it clear of the sign
  localparam int DeltaBits = CoordBits + 2;
  // signed error and 2*(dminor-dmajor): magnitude up to 2*(2^CoordBits-1)
  localparam int ErrBits   = CoordBits + 3;

  localparam logic ModeStart   = 1'b0;
  localparam logic ModeAdvance = 1'b1;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic                 mode;
    coord_t               start_x;
    coord_t               start_y;
    coord_t               end_x;
    coord_t               end_y;
    logic [ColorBits-1:0] pen_color;
  } in_item_t;

  typedef struct packed {
    logic                 pixel_valid;
    coord_t               pixel_x;
    coord_t               pixel_y;
    logic [ColorBits-1:0] pixel_color;
    logic                 last_pixel;
  } out_item_t;

  typedef struct packed {
    logic                      active;
    logic                      steep;
    coord_t                    major_pos;
    coord_t                    minor_pos;
    coord_t                    major_end;
    logic                      major_neg;
    logic                      minor_neg;
    logic signed [ErrBits-1:0] err;
    logic [DeltaBits-1:0]      twice_minor;
    logic signed [ErrBits-1:0] twice_diff;
    logic [ColorBits-1:0]      color;
  } line_state_t;

  // Pixel at the current position of a line.
  function automatic out_item_t emit_pixel(line_state_t s);
    out_item_t o;
    o.pixel_valid = 1'b1;
    o.pixel_x     = s.steep ? s.minor_pos : s.major_pos;
    o.pixel_y     = s.steep ? s.major_pos : s.minor_pos;
    o.pixel_color = s.color;
    o.last_pixel  = (s.major_pos == s.major_end);
    return o;
  endfunction

endpackage

[hw/rtl/bls_line_setup.sv]
// ----------------------------------------------------------------------------
// bls_line_setup
// Derives the initial line state (axes, step signs, deltas, error) from the
// endpoints of a start item.
// ----------------------------------------------------------------------------
module bls_line_setup (
  input  bls_pkg::in_item_t    item_i,
  output bls_pkg::line_state_t init_o
);

  bls_pkg::coord_t                  dx, dy, dmaj, dmin;
  logic                             x_neg, y_neg, steep;
  logic [bls_pkg::DeltaBits-1:0]    twice_min, twice_maj;

  always_comb begin
    x_neg = (item_i.end_x < item_i.start_x);
    y_neg = (item_i.end_y < item_i.start_y);
    dx    = x_neg ? (item_i.start_x - item_i.end_x) : (item_i.end_x - item_i.start_x);
    dy    = y_neg ? (item_i.start_y - item_i.end_y) : (item_i.end_y - item_i.start_y);
    steep = (dy > dx);
    dmaj  = steep ? dy : dx;
    dmin  = steep ? dx : dy;

    twice_min = {1'b0, dmin, 1'b0};
    twice_maj = {1'b0, dmaj, 1'b0};

    init_o.active      = 1'b1;
    init_o.steep       = steep;
    init_o.major_pos   = steep ? item_i.start_y : item_i.start_x;
    init_o.minor_pos   = steep ? item_i.start_x : item_i.start_y;
    init_o.major_end   = steep ? item_i.end_y : item_i.end_x;
    init_o.major_neg   = steep ? y_neg : x_neg;
    init_o.minor_neg   = steep ? x_neg : y_neg;
    init_o.twice_minor = twice_min;
    init_o.twice_diff  = $signed({1'b0, twice_min}) - $signed({1'b0, twice_maj});
    init_o.err         = $signed({1'b0, twice_min}) - $signed({3'b000, dmaj});
    init_o.color       = item_i.pen_color;
  end

endmodule

[hw/rtl/bls_line_state.sv]
// ----------------------------------------------------------------------------
// bls_line_state
// Line state register and the single-step Bresenham update; produces the
// result item for the item being executed.
// ----------------------------------------------------------------------------
module bls_line_state (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 exec_i,
  input  logic                 mode_i,
  input  bls_pkg::line_state_t init_i,
  output bls_pkg::out_item_t   result_o
);

  bls_pkg::line_state_t state_q, state_d, cur;

  always_comb begin
    cur      = state_q;
    result_o = '0;
    state_d  = state_q;
    if (mode_i == bls_pkg::ModeStart) begin
      cur            = init_i;
      result_o       = bls_pkg::emit_pixel(cur);
      state_d        = cur;
      state_d.active = !result_o.last_pixel;
    end else if (state_q.active) begin
      if (state_q.err < 0) begin
        cur.err = state_q.err + $signed({1'b0, state_q.twice_minor});
      end else begin
        cur.err       = state_q.err + state_q.twice_diff;
        cur.minor_pos = state_q.minor_neg ? (state_q.minor_pos - bls_pkg::CoordBits'(1))
                                          : (state_q.minor_pos + bls_pkg::CoordBits'(1));
      end
      cur.major_pos  = state_q.major_neg ? (state_q.major_pos - bls_pkg::CoordBits'(1))
                                         : (state_q.major_pos + bls_pkg::CoordBits'(1));
      result_o       = bls_pkg::emit_pixel(cur);
      state_d        = cur;
      state_d.active = !result_o.last_pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (exec_i) begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/bresenham_line_stepper.sv]
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Bresenham line rasterizer: a start item loads a line and gives its first
// pixel, each advance item gives the next pixel, last_pixel marks the end.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_ready_o | in_item_i  (bls_pkg::in_item_t)
//   out     | output    | out_valid_o / out_ready_i | out_item_o (bls_pkg::out_item_t)
//
// One item per clock sustained while the output is not stalled; an accepted
// item sits in the input register, and its result is registered in the result
// register, from which it leaves when out_ready_i is high.
// The line state is updated when an item moves from the input register to
// the result register, so back-to-back advances need no bubbles.
// Reset clears the line state (no active line) and both valid flags.
// A stalled output holds its item; the input register holds one more.
// ----------------------------------------------------------------------------
module bresenham_line_stepper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bls_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bls_pkg::out_item_t out_item_o
);

  logic                 in_valid_q, out_valid_q, exec;
  bls_pkg::in_item_t    in_q;
  bls_pkg::out_item_t   out_q, result;
  bls_pkg::line_state_t init;

  assign exec       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || exec;

  bls_line_setup u_setup (
    .item_i (in_q),
    .init_o (init)
  );

  bls_line_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (exec),
    .mode_i   (in_q.mode),
    .init_i   (init),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (exec) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[bench/bresenham_line_stepper_test.sv]
// ----------------------------------------------------------------------------
// bresenham_line_stepper_test
// Self-checking bench for the line stepper. A queue of start and advance
// items feeds a valid/ready driver. Each accepted item is traced through a
// local line rasterizer, and the monitor compares every pixel that comes out
// with the oldest predicted pixel, field by field. The run moves through
// phases of sender gaps and receiver stalls and drains fully between them.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bls_pkg::*;

  localparam int StallLimit = 2000;
  localparam int CoordMax   = (1 << CoordBits) - 1;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  bresenham_line_stepper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // line being traced by the bench, kept in step with the block
  typedef struct {
    logic                 active;
    logic                 steep;
    logic                 major_down;
    logic                 minor_down;
    coord_t               major_at;
    coord_t               minor_at;
    coord_t               major_stop;
    int                   err;
    int                   err_keep;
    int                   err_step;
    logic [ColorBits-1:0] color;
  } line_trace_t;

  line_trace_t pen = '{default: 0};
  in_item_t    cmd_queue[$];
  out_item_t   pixels_due[$];
  int          miss_count    = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          quiet_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_item_t trace_line(in_item_t it);
    out_item_t px;
    int dx, dy, dmaj, dmin;
    px = '0;
    if (it.mode == ModeStart) begin
      dx = int'(it.end_x) - int'(it.start_x);
      dy = int'(it.end_y) - int'(it.start_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      pen.steep = (dy > dx);
      if (pen.steep) begin
        pen.major_at   = it.start_y;
        pen.major_stop = it.end_y;
        pen.minor_at   = it.start_x;
        pen.major_down = (it.end_y < it.start_y);
        pen.minor_down = (it.end_x < it.start_x);
        dmaj = dy;
        dmin = dx;
      end else begin
        pen.major_at   = it.start_x;
        pen.major_stop = it.end_x;
        pen.minor_at   = it.start_y;
        pen.major_down = (it.end_x < it.start_x);
        pen.minor_down = (it.end_y < it.start_y);
        dmaj = dx;
        dmin = dy;
      end
      pen.err_keep = 2 * dmin;
      pen.err_step = 2 * dmin - 2 * dmaj;
      pen.err      = 2 * dmin - dmaj;
      pen.color    = it.pen_color;
      pen.active   = 1'b1;
    end else if (!pen.active) begin
      return px;
    end else begin
      // minor axis steps on err >= 0, ties included
      if (pen.err < 0) begin
        pen.err += pen.err_keep;
      end else begin
        pen.minor_at = pen.minor_down ? pen.minor_at - 1'b1 : pen.minor_at + 1'b1;
        pen.err += pen.err_step;
      end
      pen.major_at = pen.major_down ? pen.major_at - 1'b1 : pen.major_at + 1'b1;
    end
    px.pixel_valid = 1'b1;
    px.pixel_x     = pen.steep ? pen.minor_at : pen.major_at;
    px.pixel_y     = pen.steep ? pen.major_at : pen.minor_at;
    px.pixel_color = pen.color;
    px.last_pixel  = (pen.major_at == pen.major_stop);
    if (px.last_pixel) pen.active = 1'b0;
    return px;
  endfunction

  // advance items carry random junk in the fields they ignore
  function automatic in_item_t filler(logic mode);
    in_item_t it;
    it.mode      = mode;
    it.start_x   = coord_t'($urandom);
    it.start_y   = coord_t'($urandom);
    it.end_x     = coord_t'($urandom);
    it.end_y     = coord_t'($urandom);
    it.pen_color = ColorBits'($urandom_range(16'hFFFF));
    return it;
  endfunction

  function automatic coord_t near(coord_t c, int reach);
    int v;
    v = int'(c) + $urandom_range(2 * reach) - reach;
    if (v < 0) v = 0;
    if (v > CoordMax) v = CoordMax;
    return coord_t'(v);
  endfunction

  task automatic push_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                           logic [ColorBits-1:0] color, int n_adv);
    in_item_t it;
    it.mode      = ModeStart;
    it.start_x   = sx;
    it.start_y   = sy;
    it.end_x     = ex;
    it.end_y     = ey;
    it.pen_color = color;
    cmd_queue.push_back(it);
    repeat (n_adv) cmd_queue.push_back(filler(ModeAdvance));
  endtask

  task automatic add_random(int n_items);
    int added, r, reach, len, n_adv;
    coord_t sx, sy, ex, ey;
    added = 0;
    while (added < n_items) begin
      r = $urandom_range(99);
      if (r < 15) begin
        cmd_queue.push_back(filler(1'($urandom_range(1))));
        added++;
      end else begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        if (r < 30) begin
          // far endpoints, cut short by the next start
          ex    = coord_t'($urandom);
          ey    = coord_t'($urandom);
          n_adv = $urandom_range(6);
        end else begin
          reach = ($urandom_range(11) == 0) ? 80 : 12;
          ex    = near(sx, reach);
          ey    = near(sy, reach);
          len   = (ex > sx) ? ex - sx : sx - ex;
          if (((ey > sy) ? ey - sy : sy - ey) > len) len = (ey > sy) ? ey - sy : sy - ey;
          n_adv = len;
          if ($urandom_range(7) == 0) n_adv += $urandom_range(1, 2);
          else if ($urandom_range(7) == 0) n_adv = $urandom_range(len);
        end
        push_line(sx, sy, ex, ey, ColorBits'($urandom_range(16'hFFFF)), n_adv);
        added += 1 + n_adv;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || in_valid_i || pixels_due.size() != 0);
  endtask

  task automatic log_miss(string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    miss_count++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) pixels_due.push_back(trace_line(in_item_i));
      if (!in_valid_i || in_ready_o) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item_i  <= cmd_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixels_due.size() == 0) begin
        log_miss("pixel came out with none expected");
      end else begin
        want = pixels_due.pop_front();
        if (out_item_o.pixel_valid !== want.pixel_valid)
          log_miss($sformatf("pixel_valid got %0b want %0b",
                             out_item_o.pixel_valid, want.pixel_valid));
        if (out_item_o.pixel_x !== want.pixel_x)
          log_miss($sformatf("pixel_x got %0d want %0d", out_item_o.pixel_x, want.pixel_x));
        if (out_item_o.pixel_y !== want.pixel_y)
          log_miss($sformatf("pixel_y got %0d want %0d", out_item_o.pixel_y, want.pixel_y));
        if (out_item_o.pixel_color !== want.pixel_color)
          log_miss($sformatf("pixel_color got %h want %h",
                             out_item_o.pixel_color, want.pixel_color));
        if (out_item_o.last_pixel !== want.last_pixel)
          log_miss($sformatf("last_pixel got %0b want %0b",
                             out_item_o.last_pixel, want.last_pixel));
      end
    end
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t ns watchdog: no item moved in %0d cycles", $realtime, StallLimit);
      $display("bresenham_line_stepper_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // advance before any line: empty pixel
    cmd_queue.push_back('{mode: ModeAdvance, start_x: 9'h1FF, start_y: 9'h1FF,
                          end_x: 9'h1FF, end_y: 9'h1FF, pen_color: 16'hFFFF});
    // single-pixel line, then an advance on the dead line
    push_line(9'd7, 9'd9, 9'd7, 9'd9, 16'hFFFF, 1);
    // error term hits zero on the first step
    push_line(9'd0, 9'd0, 9'd2, 9'd1, 16'h0000, 2);
    // steep, both axes counting down
    push_line(9'd511, 9'd511, 9'd510, 9'd508, 16'hF800, 3);
    // longest deltas, each dropped by the next start
    push_line(9'd0, 9'd0, 9'd511, 9'd511, 16'h07E0, 2);
    push_line(9'd0, 9'd511, 9'd511, 9'd0, 16'h001F, 2);
    push_line(9'd511, 9'd0, 9'd0, 9'd3, 16'hAAAA, 1);
    // x down, y up, one advance past the end
    push_line(9'd300, 9'd200, 9'd297, 9'd201, 16'h5555, 4);
    add_random(130);
    wait_drained();

    send_idle_pct = 50;
    stall_pct     = 0;
    add_random(130);
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 50;
    add_random(130);
    wait_drained();

    send_idle_pct = 36;
    stall_pct     = 36;
    add_random(130);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (miss_count == 0) begin
      $display("bresenham_line_stepper_test: PASS");
    end else begin
      $display("bresenham_line_stepper_test: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bls_pkg.sv
hw/rtl/bls_line_setup.sv
hw/rtl/bls_line_state.sv
hw/rtl/bresenham_line_stepper.sv
bench/bresenham_line_stepper_test.sv
